>>> hdl/differential_drive_odometry_assert.svh
// Assertion macros for the differential-drive odometry block.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

`ifndef SYNTHESIS
`define DDO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
`define DDO_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");
`else
`define DDO_ASSERT(lbl, prop)
`define DDO_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

>>> hdl/ddo_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the odometry block.
// No dependencies.
package ddo_pkg;

  localparam int CfgAddrW = 8;
  localparam int CfgDataW = 16;
  localparam int RotW     = 16;
  localparam int PoseW    = 32;
  localparam int HeadW    = 15;
  localparam int InDataW  = 32;
  localparam int OutDataW = 80;

  localparam logic [CfgAddrW-1:0] RegWheelRadius = 8'd0;
  localparam logic [CfgAddrW-1:0] RegInvWheelBase = 8'd1;
  localparam logic [CfgDataW-1:0] WheelRadiusReset = 16'd5079;
  localparam logic [CfgDataW-1:0] InvWheelBaseReset = 16'd14895;

  // Serial multiplier: signed multiplicand, signed multiplier taken MSB first
  localparam int MulAW   = 33;
  localparam int MulBW   = 32;
  localparam int ProdW   = 64;
  localparam int MulCntW = 6;
  localparam logic [MulCntW-1:0] MulFullSteps   = 6'd32;
  localparam logic [MulCntW-1:0] MulNarrowSteps = 6'd17;

  // CORDIC
  localparam int CordXW = 34;
  localparam int CordZW = 33;
  localparam int TrigW  = 32;
  localparam int TabLen = 24;
  localparam int CordicStepsDefault = 14;
  localparam logic signed [CordXW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [CordXW-1:0] OneQ30  = 34'sd1073741824;

  localparam logic signed [15:0] PiQ12     = 16'sd12868;
  localparam logic signed [15:0] HalfPiQ12 = 16'sd6434;
  localparam logic signed [15:0] TwoPiQ12  = 16'sd25736;

  typedef struct packed {
    logic start;
    logic narrow;
  } mul_ctrl_t;

  function automatic logic signed [CordZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CordZW-1:0] v;
    unique case (idx)
      5'd0:    v = 33'sd843314856;
      5'd1:    v = 33'sd497837829;
      5'd2:    v = 33'sd263043836;
      5'd3:    v = 33'sd133525158;
      5'd4:    v = 33'sd67021686;
      5'd5:    v = 33'sd33543515;
      5'd6:    v = 33'sd16775850;
      5'd7:    v = 33'sd8388437;
      5'd8:    v = 33'sd4194282;
      5'd9:    v = 33'sd2097149;
      5'd10:   v = 33'sd1048575;
      5'd11:   v = 33'sd524287;
      5'd12:   v = 33'sd262143;
      5'd13:   v = 33'sd131071;
      5'd14:   v = 33'sd65535;
      5'd15:   v = 33'sd32767;
      5'd16:   v = 33'sd16383;
      5'd17:   v = 33'sd8191;
      5'd18:   v = 33'sd4095;
      5'd19:   v = 33'sd2047;
      5'd20:   v = 33'sd1023;
      5'd21:   v = 33'sd511;
      5'd22:   v = 33'sd255;
      5'd23:   v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/differential_drive_odometry.sv
// Differential-drive dead-reckoning odometry, top level.
// Channels: s_axis carries one pair of wheel rotation increments per item
// (left in tdata[15:0], right in tdata[31:16], signed Q3.12 radians).
// m_axis returns one pose per input item: x in tdata[31:0], y in
// tdata[63:32] (signed Q16.16 meters, saturating), heading in tdata[78:64]
// (signed Q3.12, wrapped to [-pi, pi]).
// The cfg channel writes the wheel radius (index 0) and inverse_wheel_base
// (index 1), both unsigned Q2.14; other indexes are ignored. Write it only
// while no item is in flight. cfg_ready_o is always high.
// Each item passes in turn through two rounds of 17-step bit-serial multiplies
// for travel and turn, the iterative CORDIC at one iteration per cycle,
// 32-step bit-serial multiplies for the position increments, and a handoff
// between stages. Items are processed one at a time; s_axis_tready is high
// while the datapath is free, so no new item is taken before the last one
// has been committed. A finished pose waits in the output register, so the
// next item can be taken while m_axis is stalled; the pose update for that
// item holds until the register drains.
// Reset clears pose and heading to zero and loads the default geometry.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ddo_pkg::InDataW-1:0]     s_axis_tdata,  // left_rotation, right_rotation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ddo_pkg::OutDataW-1:0]    m_axis_tdata,  // pose_x, pose_y, heading, pad
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ddo_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [ddo_pkg::CfgDataW-1:0]    cfg_data_i
);
  import ddo_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul1 = 6'b000010,
    StMul2 = 6'b000100,
    StCord = 6'b001000,
    StMul3 = 6'b010000,
    StUpd  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CfgDataW-1:0]     wr_q, iwb_q;
  logic signed [PoseW-1:0] pos_x_q, pos_y_q;
  logic signed [HeadW-1:0] heading_q;
  logic signed [MulAW-1:0] travel_q;

  logic                    out_valid_q;
  logic signed [PoseW-1:0] out_x_q, out_y_q;
  logic signed [HeadW-1:0] out_h_q;

  mul_ctrl_t               mul0_ctrl, mul1_ctrl;
  logic signed [MulAW-1:0] mul0_a, mul1_a;
  logic signed [MulBW-1:0] mul0_b, mul1_b;
  logic                    mul0_done, mul1_done;
  logic signed [ProdW-1:0] mul0_p, mul1_p;

  logic                    cord_start, cord_done;
  logic signed [TrigW-1:0] cos_v, sin_v;

  logic                    in_accept, out_free;
  logic signed [RotW:0]    rot_sum, rot_diff;
  logic signed [48:0]      turn, turn_rnd, dth_full;
  logic signed [HeadW-1:0] dth, heading_new;
  logic signed [15:0]      h_sum, h_wrap;
  logic signed [PoseW-1:0] pos_x_new, pos_y_new;

  function automatic logic signed [PoseW-1:0] pose_step(
    input logic signed [PoseW-1:0] pos,
    input logic signed [ProdW-1:0] prod
  );
    logic signed [ProdW-1:0] rnd;
    logic signed [PoseW:0]   inc, acc;
    logic signed [PoseW-1:0] res;
    rnd = (prod + 64'sd1099511627776) >>> 41;
    inc = signed'(rnd[PoseW:0]);
    acc = {pos[PoseW-1], pos} + inc;
    // Saturate to the signed 32-bit range
    if (acc > 33'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (acc < -33'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = acc[PoseW-1:0];
    end
    return res;
  endfunction

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    rot_sum  = {s_axis_tdata[15], s_axis_tdata[15:0]} + {s_axis_tdata[31], s_axis_tdata[31:16]};
    rot_diff = {s_axis_tdata[31], s_axis_tdata[31:16]} - {s_axis_tdata[15], s_axis_tdata[15:0]};

    // Heading change, rounded to Q3.12 and clamped to +/- pi
    turn     = mul1_p[48:0];
    turn_rnd = turn + 49'sd134217728;
    dth_full = turn_rnd >>> 28;
    if (dth_full > 49'sd12868) begin
      dth = 15'sd12868;
    end else if (dth_full < -49'sd12868) begin
      dth = -15'sd12868;
    end else begin
      dth = dth_full[HeadW-1:0];
    end
    h_sum = {heading_q[HeadW-1], heading_q} + {dth[HeadW-1], dth};
    if (h_sum > PiQ12) begin
      h_wrap = h_sum - TwoPiQ12;
    end else if (h_sum < -PiQ12) begin
      h_wrap = h_sum + TwoPiQ12;
    end else begin
      h_wrap = h_sum;
    end
    heading_new = h_wrap[HeadW-1:0];

    pos_x_new = pose_step(pos_x_q, mul0_p);
    pos_y_new = pose_step(pos_y_q, mul1_p);
  end

  // Multiplier operand steering, CORDIC start and next-state logic
  always_comb begin
    mul0_ctrl  = '0;
    mul1_ctrl  = '0;
    mul0_a     = MulAW'(rot_sum);
    mul1_a     = MulAW'(rot_diff);
    mul0_b     = MulBW'(wr_q);
    mul1_b     = MulBW'(wr_q);
    cord_start = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      StIdle: begin
        mul0_ctrl = '{start: in_accept, narrow: 1'b1};
        mul1_ctrl = '{start: in_accept, narrow: 1'b1};
        if (in_accept) begin
          state_d = StMul1;
        end
      end
      StMul1: begin
        mul1_a    = mul1_p[MulAW-1:0];
        mul1_b    = MulBW'(iwb_q);
        mul1_ctrl = '{start: mul1_done, narrow: 1'b1};
        if (mul1_done) begin
          state_d = StMul2;
        end
      end
      StMul2: begin
        cord_start = mul1_done;
        if (mul1_done) begin
          state_d = StCord;
        end
      end
      StCord: begin
        mul0_a    = travel_q;
        mul1_a    = travel_q;
        mul0_b    = cos_v;
        mul1_b    = sin_v;
        mul0_ctrl = '{start: cord_done, narrow: 1'b0};
        mul1_ctrl = '{start: cord_done, narrow: 1'b0};
        if (cord_done) begin
          state_d = StMul3;
        end
      end
      StMul3: begin
        if (mul0_done) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  ddo_serial_mul u_mul0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul0_ctrl),
    .a_i    (mul0_a),
    .b_i    (mul0_b),
    .done_o (mul0_done),
    .p_o    (mul0_p)
  );

  ddo_serial_mul u_mul1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul1_ctrl),
    .a_i    (mul1_a),
    .b_i    (mul1_b),
    .done_o (mul1_done),
    .p_o    (mul1_p)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (heading_new),
    .done_o  (cord_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wr_q        <= WheelRadiusReset;
      iwb_q       <= InvWheelBaseReset;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_addr_i == RegWheelRadius) begin
          wr_q <= cfg_data_i;
        end else if (cfg_addr_i == RegInvWheelBase) begin
          iwb_q <= cfg_data_i;
        end
      end
      if (state_q == StMul2 && mul1_done) begin
        heading_q <= heading_new;
      end
      // Commit the pose and present it once the output register is free
      if (state_q == StUpd && out_free) begin
        pos_x_q     <= pos_x_new;
        pos_y_q     <= pos_y_new;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StMul1 && mul1_done) begin
      travel_q <= mul0_p[MulAW-1:0];
    end
    if (state_q == StUpd && out_free) begin
      out_x_q <= pos_x_new;
      out_y_q <= pos_y_new;
      out_h_q <= heading_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_h_q, out_y_q, out_x_q};

  `include "differential_drive_odometry_assert.svh"

  `DDO_ASSERT(heading_in_range_a, (heading_q <= 15'sd12868) && (heading_q >= -15'sd12868))
  `DDO_ASSERT_IMPLIES(mul_pair_done_a, (state_q == StMul1) && mul1_done, mul0_done)
  `DDO_ASSERT_IMPLIES(cordic_done_state_a, cord_done, state_q == StCord)
  `DDO_ASSERT_IMPLIES(idle_mul_quiet_a, state_q == StIdle, !mul0_done && !mul1_done)

endmodule

>>> hdl/ddo_serial_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle, MSB first.
// Depends on ddo_pkg.
module ddo_serial_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ddo_pkg::mul_ctrl_t              ctrl_i,
  input  logic signed [ddo_pkg::MulAW-1:0] a_i,
  input  logic signed [ddo_pkg::MulBW-1:0] b_i,
  output logic                            done_o,
  output logic signed [ddo_pkg::ProdW-1:0] p_o
);
  import ddo_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic                    first_q, first_d;
  logic [MulCntW-1:0]      cnt_q, cnt_d;
  logic [MulBW-1:0]        b_q, b_d;
  logic signed [ProdW-1:0] a_q, a_d;
  logic signed [ProdW-1:0] acc_q, acc_d;
  logic signed [ProdW-1:0] term;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    first_d = first_q;
    cnt_d   = cnt_q;
    b_d     = b_q;
    a_d     = a_q;
    acc_d   = acc_q;
    // The top multiplier bit carries negative weight
    if (b_q[MulBW-1]) begin
      term = first_q ? -a_q : a_q;
    end else begin
      term = '0;
    end
    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      a_d     = ProdW'(a_i);
      acc_d   = '0;
      if (ctrl_i.narrow) begin
        b_d   = {b_i[16:0], 15'b0};
        cnt_d = MulNarrowSteps;
      end else begin
        b_d   = b_i;
        cnt_d = MulFullSteps;
      end
    end else if (busy_q) begin
      acc_d   = (acc_q <<< 1) + term;
      b_d     = {b_q[MulBW-2:0], 1'b0};
      first_d = 1'b0;
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == MulCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> hdl/ddo_cordic.sv
// Iterative rotation-mode CORDIC: cos and sin of a Q3.12 heading in Q30.
// Depends on ddo_pkg.
module ddo_cordic #(
  parameter int unsigned STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ddo_pkg::HeadW-1:0] angle_i,
  output logic                             done_o,
  output logic signed [ddo_pkg::TrigW-1:0] cos_o,
  output logic signed [ddo_pkg::TrigW-1:0] sin_o
);
  import ddo_pkg::*;

  localparam int IdxW = $clog2(STEPS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(STEPS - 1);

  logic                     busy_q, fin_q, done_q, neg_q;
  logic [IdxW-1:0]          i_q;
  logic signed [CordXW-1:0] x_q, y_q;
  logic signed [CordZW-1:0] z_q;
  logic signed [TrigW-1:0]  cos_q, sin_q;

  logic signed [15:0]       ang_ext, ang_fold;
  logic                     fold_neg;
  logic signed [CordZW-1:0] z_init, at;
  logic signed [CordXW-1:0] xs, ys, xc, yc;

  always_comb begin
    ang_ext  = {angle_i[HeadW-1], angle_i};
    fold_neg = 1'b0;
    ang_fold = ang_ext;
    // Fold into [-pi/2, pi/2]; the results flip sign
    if (ang_ext > HalfPiQ12) begin
      ang_fold = ang_ext - PiQ12;
      fold_neg = 1'b1;
    end else if (ang_ext < -HalfPiQ12) begin
      ang_fold = ang_ext + PiQ12;
      fold_neg = 1'b1;
    end
    z_init = CordZW'(ang_fold) <<< 18;
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    at     = atan_q30(5'(i_q));
    if (x_q > OneQ30) begin
      xc = OneQ30;
    end else if (x_q < -OneQ30) begin
      xc = -OneQ30;
    end else begin
      xc = x_q;
    end
    if (y_q > OneQ30) begin
      yc = OneQ30;
    end else if (y_q < -OneQ30) begin
      yc = -OneQ30;
    end else begin
      yc = y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && i_q == LastIdx) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= GainQ30;
      y_q   <= '0;
      z_q   <= z_init;
      i_q   <= '0;
      neg_q <= fold_neg;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
      i_q <= i_q + 1'b1;
    end
    if (fin_q) begin
      cos_q <= neg_q ? TrigW'(-xc) : TrigW'(xc);
      sin_q <= neg_q ? TrigW'(-yc) : TrigW'(yc);
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule
